// File: sv/ssm_pkg.sv
// Shared constants, opcodes and types of the substring search matcher.
package ssm_pkg;

    localparam int PAT_MAX   = 16;
    localparam int PAT_LEN_W = $clog2(PAT_MAX + 1);
    localparam int COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] TEXT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_PAT_BYTE   = 2'd0,
        OP_PAT_EMPTY  = 2'd1,
        OP_TEXT_BYTE  = 2'd2,
        OP_TEXT_EMPTY = 2'd3
    } opcode_t;

    typedef logic [PAT_MAX-1:0][7:0] byte_vec_t;

    typedef struct packed {
        opcode_t    op;
        logic [7:0] data;
        logic       last;
        logic       anchored;
    } item_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] offset;
        logic [COUNT_W-1:0] length;
        logic               overflow;
    } result_t;

endpackage

// File: sv/substring_search_matcher.sv
// Top level of the substring search matcher: input word register, core, result register.
//
// Usage. Words arrive on the input channel (in_valid, in_stall) with an opcode:
// pattern byte, empty pattern, text byte or empty text. A pattern is loaded one
// byte per word, newest last, and ends with is_last or with the first text word.
// Text then streams one byte per word; the last text byte (is_last) or an empty
// text word produces exactly one result word on the output channel (out_valid,
// out_stall): found, match_offset, text_length and overflow. anchored is only
// looked at on the word that ends a text.
// out_valid rises once the ending word has been accepted and passed through the input
// register: the word waits there while the window is compared, and the result register
// takes the outcome when the word leaves the input register.
// Throughput is one word per cycle while no word that ends a text waits on a held result;
// the compare of all sixteen window bytes is done in parallel, between the two registers.
// When the receiver stalls with a result held, the block still accepts and
// processes words that produce no result; a word that ends a text waits in the
// input register, and in_stall rises, until the held result has been taken.
// Reset clears the pattern length, the text state and both valid flags; the
// block accepts words straight after reset is released.
module substring_search_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic        anchored,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [15:0] match_offset,
    output logic [15:0] text_length,
    output logic        overflow
);
    import ssm_pkg::*;

    logic                 in_valid_reg;
    item_t                item_reg;
    logic                 emits;
    logic                 out_free;
    logic                 fire;
    byte_vec_t            pat;
    logic [PAT_LEN_W-1:0] pat_len;
    result_t              res;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              res_reg;

    // Only the word that ends a text needs the result register to be free.
    assign emits    = (item_reg.op == OP_TEXT_EMPTY) ||
                      ((item_reg.op == OP_TEXT_BYTE) && item_reg.last);
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && (!emits || out_free);
    assign in_stall = in_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.op       <= opcode_t'(opcode);
            item_reg.data     <= data_byte;
            item_reg.last     <= is_last;
            item_reg.anchored <= anchored;
        end
    end

    ssm_pattern u_pattern (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item_reg),
        .pat     (pat),
        .pat_len (pat_len)
    );

    ssm_text u_text (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item_reg),
        .pat     (pat),
        .pat_len (pat_len),
        .result  (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && emits)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emits)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = res_reg.found;
    assign match_offset = res_reg.offset;
    assign text_length  = res_reg.length;
    assign overflow     = res_reg.overflow;

endmodule

// File: sv/ssm_pattern.sv
// Pattern store: holds the seek pattern newest byte first, with its length.
module ssm_pattern (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  ssm_pkg::item_t             item,
    output ssm_pkg::byte_vec_t         pat,
    output logic [ssm_pkg::PAT_LEN_W-1:0] pat_len
);
    import ssm_pkg::*;

    byte_vec_t            pat_reg;
    byte_vec_t            pat_next;
    logic [PAT_LEN_W-1:0] len_reg;
    logic [PAT_LEN_W-1:0] len_next;
    logic [PAT_LEN_W-1:0] len_base;
    logic                 loading_reg;
    logic                 loading_next;

    // Shifting each byte in at position 0 puts pattern byte len-1-k at
    // position k, which lines it up with the text window.
    always_comb
    begin
        pat_next     = pat_reg;
        len_next     = len_reg;
        loading_next = loading_reg;
        len_base     = loading_reg ? len_reg : '0;
        if (fire)
        begin
            case (item.op)
                OP_PAT_BYTE:
                begin
                    len_next = len_base;
                    if (len_base < PAT_LEN_W'(PAT_MAX))
                    begin
                        pat_next = {pat_reg[PAT_MAX-2:0], item.data};
                        len_next = len_base + 1'b1;
                    end
                    loading_next = !item.last;
                end
                OP_PAT_EMPTY:
                begin
                    len_next     = '0;
                    loading_next = 1'b0;
                end
                default:
                begin
                    loading_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            loading_reg <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            loading_reg <= loading_next;
        end
    end

    assign pat     = pat_reg;
    assign pat_len = len_reg;

endmodule

// File: sv/ssm_text.sv
// Text window, byte count and parallel window compare against the pattern.
module ssm_text (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  ssm_pkg::item_t                item,
    input  ssm_pkg::byte_vec_t            pat,
    input  logic [ssm_pkg::PAT_LEN_W-1:0] pat_len,
    output ssm_pkg::result_t              result
);
    import ssm_pkg::*;

    byte_vec_t          win_reg;
    byte_vec_t          win_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               found_reg;
    logic               found_next;
    logic [COUNT_W-1:0] pos_reg;
    logic [COUNT_W-1:0] pos_next;
    logic               ovf_reg;
    logic               ovf_next;
    byte_vec_t          win_cur;
    logic [COUNT_W-1:0] count_cur;
    logic               found_cur;
    logic [COUNT_W-1:0] pos_cur;
    logic               ovf_cur;
    logic               window_eq;
    logic               rep_found;
    logic [COUNT_W-1:0] rep_pos;

    assign win_cur   = {win_reg[PAT_MAX-2:0], item.data};
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        window_eq = 1'b1;
        for (int k = 0; k < PAT_MAX; k++)
        begin
            if ((PAT_LEN_W'(k) < pat_len) && (win_cur[k] != pat[k]))
            begin
                window_eq = 1'b0;
            end
        end
    end

    always_comb
    begin
        count_cur = count_reg;
        found_cur = found_reg;
        pos_cur   = pos_reg;
        ovf_cur   = ovf_reg;
        if (count_reg == TEXT_MAX)
        begin
            ovf_cur = 1'b1;
        end
        else
        begin
            count_cur = count_inc;
            if (!found_reg && (pat_len != '0) && (count_inc >= COUNT_W'(pat_len))
                && window_eq)
            begin
                found_cur = 1'b1;
                pos_cur   = count_inc - COUNT_W'(pat_len);
            end
        end
    end

    always_comb
    begin
        win_next   = win_reg;
        count_next = count_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        rep_found  = 1'b0;
        rep_pos    = '0;
        result     = '0;
        if (item.op == OP_TEXT_BYTE)
        begin
            rep_found = found_cur;
            rep_pos   = pos_cur;
            result.length   = count_cur;
            result.overflow = ovf_cur;
        end
        if (pat_len == '0)
        begin
            rep_found = 1'b1;
            rep_pos   = '0;
        end
        if (item.anchored && (rep_pos != '0))
        begin
            rep_found = 1'b0;
        end
        result.found  = rep_found;
        result.offset = rep_found ? rep_pos : '0;
        if (fire)
        begin
            if ((item.op == OP_TEXT_BYTE) && !item.last)
            begin
                win_next   = win_cur;
                count_next = count_cur;
                found_next = found_cur;
                pos_next   = pos_cur;
                ovf_next   = ovf_cur;
            end
            else
            begin
                // Pattern items, empty text and the end of a text all clear.
                win_next   = '0;
                count_next = '0;
                found_next = 1'b0;
                pos_next   = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            win_reg   <= win_next;
            count_reg <= count_next;
            found_reg <= found_next;
            pos_reg   <= pos_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// File: tb/sv/substring_search_matcher_checker.sv
// Checker for the substring search matcher: predicts every result word and compares it.
module substring_search_matcher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic        anchored,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        found,
    input  logic [15:0] match_offset,
    input  logic [15:0] text_length,
    input  logic        overflow,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ssm_pkg::*;

    // Predicted state of the matcher.
    logic [7:0] pat_bytes [PAT_MAX];
    int         pat_len;
    logic [7:0] window [PAT_MAX];
    int         text_count;
    logic       seen_match;
    int         match_pos;
    logic       text_overflow;
    logic       loading;

    result_t    awaited_results [$];

    function automatic void clear_text();
        foreach (window[k])
            window[k] = 8'h00;
        text_count    = 0;
        seen_match    = 1'b0;
        match_pos     = 0;
        text_overflow = 1'b0;
    endfunction

    // Window entry 0 is the newest text byte, so it lines up with the last pattern byte.
    function automatic logic window_equals_pattern();
        for (int k = 0; k < pat_len; k++)
            if (window[k] != pat_bytes[pat_len-1-k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void close_text(input logic anch);
        result_t r;
        logic    hit;
        int      pos;
        hit = seen_match;
        pos = match_pos;
        if (pat_len == 0)
        begin
            hit = 1'b1;
            pos = 0;
        end
        if (anch && pos != 0)
            hit = 1'b0;
        r.found    = hit;
        r.offset   = hit ? 16'(pos) : '0;
        r.length   = 16'(text_count);
        r.overflow = text_overflow;
        awaited_results.push_back(r);
        clear_text();
    endfunction

    function automatic void advance_matcher(input opcode_t op, input logic [7:0] data,
                                            input logic last, input logic anch);
        case (op)
            OP_PAT_BYTE:
            begin
                clear_text();
                if (!loading)
                    pat_len = 0;
                if (pat_len < PAT_MAX)
                begin
                    pat_bytes[pat_len] = data;
                    pat_len++;
                end
                loading = !last;
            end
            OP_PAT_EMPTY:
            begin
                clear_text();
                pat_len = 0;
                loading = 1'b0;
            end
            OP_TEXT_BYTE:
            begin
                loading = 1'b0;
                for (int k = PAT_MAX - 1; k > 0; k--)
                    window[k] = window[k-1];
                window[0] = data;
                if (text_count >= int'(TEXT_MAX))
                    text_overflow = 1'b1;
                else
                begin
                    text_count++;
                    if (!seen_match && pat_len > 0 && text_count >= pat_len &&
                        window_equals_pattern())
                    begin
                        seen_match = 1'b1;
                        match_pos  = text_count - pat_len;
                    end
                end
                if (last)
                    close_text(anch);
            end
            default:
            begin
                loading = 1'b0;
                clear_text();
                close_text(anch);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            foreach (pat_bytes[k])
                pat_bytes[k] = 8'h00;
            pat_len = 0;
            loading = 1'b0;
            clear_text();
            awaited_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        fail_count++;
                    end
                    if (match_offset !== want.offset)
                    begin
                        $error("match_offset: expected %0d, got %0d", want.offset, match_offset);
                        fail_count++;
                    end
                    if (text_length !== want.length)
                    begin
                        $error("text_length: expected %0d, got %0d", want.length, text_length);
                        fail_count++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", want.overflow, overflow);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                advance_matcher(opcode_t'(opcode), data_byte, is_last, anchored);
            pending = awaited_results.size();
        end
    end

endmodule

// File: tb/sv/substring_search_matcher_tb.sv
// Testbench top for the substring search matcher: clock, reset, stimulus and verdict.
module substring_search_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    opcode_t     opcode;
    logic [7:0]  data_byte;
    logic        is_last;
    logic        anchored;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic [15:0] match_offset;
    logic [15:0] text_length;
    logic        overflow;

    int          fail_count;
    int          pending;

    // Idle rates in percent for the sending and the receiving side.
    int          send_pct = 16;
    int          recv_pct = 55;
    int          sent_words = 0;

    always #4 clk = ~clk;

    substring_search_matcher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .is_last      (is_last),
        .anchored     (anchored),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .match_offset (match_offset),
        .text_length  (text_length),
        .overflow     (overflow)
    );

    substring_search_matcher_checker result_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .is_last      (is_last),
        .anchored     (anchored),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .match_offset (match_offset),
        .text_length  (text_length),
        .overflow     (overflow),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // The receiver decides afresh on every falling edge whether to hold off the next result.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_pct);

    // Offers one word and returns at the falling edge after it has been taken. It is always
    // entered at a falling edge, and each pass of the idle loop waits on a falling edge, so the
    // valid line gets only one assignment in any time step.
    task automatic send_word(input opcode_t op, input logic [7:0] data,
                             input logic last, input logic anch);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= data;
        is_last   <= last;
        anchored  <= anch;
        do
            @(posedge clk);
        while (in_stall);
        sent_words++;
        @(negedge clk);
    endtask

    // Sends a pattern; an unterminated one is left open for the next word to close.
    task automatic send_pattern(input logic [7:0] bytes [$], input logic terminated);
        foreach (bytes[k])
            send_word(OP_PAT_BYTE, bytes[k], terminated && (k == bytes.size() - 1),
                      1'($urandom_range(1)));
    endtask

    // Sends text bytes. With closed set the last one carries is_last and the anchored
    // flag that counts; the anchored bit of earlier bytes is noise the block must ignore.
    task automatic send_text(input logic [7:0] bytes [$], input logic anch, input logic closed);
        logic final_byte;
        foreach (bytes[k])
        begin
            final_byte = closed && (k == bytes.size() - 1);
            send_word(OP_TEXT_BYTE, bytes[k], final_byte,
                      final_byte ? anch : 1'($urandom_range(1)));
        end
    endtask

    // Half of the bytes come from a four-letter alphabet so that texts match often.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(1) == 1)
            return 8'(8'h61 + $urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    // Lowers valid and holds it low until every expected result word has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // One random session: mostly a pattern followed by a few texts built around it,
    // sometimes a lone random word of any kind to break sequences up.
    task automatic random_session();
        logic [7:0] pat_q [$];
        logic [7:0] txt [$];
        int         plen;
        if ($urandom_range(99) < 15)
        begin
            send_word(opcode_t'($urandom_range(3)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
            return;
        end
        // Lengths above sixteen exercise the truncation of long patterns.
        plen = $urandom_range(19);
        if (plen == 0)
            send_word(OP_PAT_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        else
        begin
            repeat (plen)
                pat_q.push_back(pick_byte());
            // Now and then the pattern is left open and the first text word closes it.
            send_pattern(pat_q, $urandom_range(9) != 0);
        end
        repeat ($urandom_range(1, 4))
        begin
            txt = {};
            repeat ($urandom_range(6))
                txt.push_back(pick_byte());
            if ($urandom_range(99) < 65)
            begin
                foreach (pat_q[j])
                    txt.push_back(pat_q[j]);
                // A single corrupted byte gives near misses.
                if (pat_q.size() > 0 && $urandom_range(4) == 0)
                    txt[$urandom_range(txt.size() - 1)] = pick_byte();
            end
            repeat ($urandom_range(6))
                txt.push_back(pick_byte());
            if (txt.size() == 0 || $urandom_range(9) == 0)
            begin
                // An empty text word, possibly abandoning the bytes sent before it.
                if (txt.size() != 0)
                    send_text(txt, 1'b0, 1'b0);
                send_word(OP_TEXT_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
            else
                send_text(txt, $urandom_range(3) == 0, 1'b1);
        end
    endtask

    task automatic run_random(input int words);
        int start;
        start = sent_words;
        while (sent_words - start < words)
            random_session();
    endtask

    initial
    begin
        logic [7:0] pat_q [$];
        logic [7:0] txt [$];
        int         guard;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = OP_PAT_EMPTY;
        data_byte = 8'h00;
        is_last   = 1'b0;
        anchored  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with the sender idling lightly and the receiver heavily.
        // An empty pattern with every ignored input set, then an empty text: found at zero.
        send_word(OP_PAT_EMPTY, 8'hFF, 1'b1, 1'b1);
        send_word(OP_TEXT_EMPTY, 8'hFF, 1'b1, 1'b1);
        // An empty pattern matches any text at offset zero, even when anchored.
        txt = '{8'h00, 8'hFF};
        send_text(txt, 1'b1, 1'b1);
        // A two-byte pattern at the extremes of the byte range.
        pat_q = '{8'hFF, 8'h00};
        send_pattern(pat_q, 1'b1);
        // A text shorter than the pattern never matches.
        txt = '{8'h00};
        send_text(txt, 1'b0, 1'b1);
        // A match at offset one: rejected when anchored, reported otherwise.
        txt = '{8'h12, 8'hFF, 8'h00};
        send_text(txt, 1'b1, 1'b1);
        send_text(txt, 1'b0, 1'b1);
        // A match at offset zero survives the anchored check.
        txt = '{8'hFF, 8'h00};
        send_text(txt, 1'b1, 1'b1);
        // An unterminated pattern, closed by the first text byte.
        send_word(OP_PAT_BYTE, 8'hAA, 1'b0, 1'b0);
        txt = '{8'hAA};
        send_text(txt, 1'b0, 1'b1);
        // A pattern word in the middle of a text abandons the text without a result.
        send_word(OP_TEXT_BYTE, 8'h55, 1'b0, 1'b0);
        send_word(OP_PAT_BYTE, 8'h55, 1'b1, 1'b0);
        send_word(OP_TEXT_EMPTY, 8'h00, 1'b0, 1'b0);
        // An empty pattern word closes an open pattern; an empty text drops a text in progress.
        send_word(OP_PAT_BYTE, 8'h01, 1'b0, 1'b0);
        send_word(OP_PAT_EMPTY, 8'h00, 1'b0, 1'b0);
        send_word(OP_TEXT_BYTE, 8'h01, 1'b0, 1'b1);
        send_word(OP_TEXT_EMPTY, 8'h00, 1'b0, 1'b0);

        run_random(420);
        drain_results();

        // The sides swap their idle rates.
        send_pct = 55;
        recv_pct = 16;
        run_random(420);
        drain_results();

        // From here on neither side idles.
        send_pct = 0;
        recv_pct = 0;

        run_random(420);

        // Wait for the last results, then keep watching for anything unexpected.
        in_valid <= 1'b0;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while (pending != 0 && guard < 20000);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
